/* hw/rtl/mouse_motion_packetizer_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the mouse motion packetizer
// Checks are written against i_clk and are disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MOUSE_MOTION_PACKETIZER_TOP_ASSERT_SVH
`define MOUSE_MOTION_PACKETIZER_TOP_ASSERT_SVH

// same-cycle implication
`define MMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mmp_pkg.sv */
// ---------------------------------------------------------------------------
// mmp_pkg
// Types, constants, microcode table and helper functions of the packetizer.
// ---------------------------------------------------------------------------
package mmp_pkg;

    localparam int COORD_BITS = 12;
    localparam int PEND_W     = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic signed [PEND_W-1:0] t_pend;

    localparam t_pend CHUNK_MAX = t_pend'(255);

    localparam logic [1:0] KIND_MOTION  = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [2:0] BTN_LEFT   = 3'd1;
    localparam logic [2:0] BTN_MIDDLE = 3'd2;
    localparam logic [2:0] BTN_RIGHT  = 3'd3;
    localparam logic [2:0] BTN_UP     = 3'd4;
    localparam logic [2:0] BTN_DOWN   = 3'd5;

    localparam logic [7:0] FLAG_SIGNY  = 8'h20;
    localparam logic [7:0] FLAG_SIGNX  = 8'h10;
    localparam logic [7:0] FLAG_MIDDLE = 8'h04;
    localparam logic [7:0] FLAG_RIGHT  = 8'h02;
    localparam logic [7:0] FLAG_LEFT   = 8'h01;

    localparam logic [7:0] WHEEL_UP   = 8'hff;
    localparam logic [7:0] WHEEL_DOWN = 8'h01;
    localparam logic [7:0] WHEEL_IDLE = 8'h00;

    localparam logic [7:0] BYTE_POS_MAX = 8'hff;
    localparam logic [7:0] BYTE_NEG_MAX = 8'h01;

    typedef logic [1:0] t_step;

    localparam t_step STEP_IDLE  = 2'd0;
    localparam t_step STEP_CHECK = 2'd1;
    localparam t_step STEP_EMIT  = 2'd2;

    typedef enum logic [1:0] {
        COND_REQ,
        COND_EMPTY,
        COND_DONE
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  emit;
        t_cond cond;
        t_step jmp_true;
        t_step jmp_false;
    } t_uop;

    typedef struct packed {
        logic [7:0] mv;
        t_pend      rest;
    } t_chunk;

    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        unique case (step)
            STEP_IDLE:  u = '{accept: 1'b1, emit: 1'b0, cond: COND_REQ,
                              jmp_true: STEP_CHECK, jmp_false: STEP_IDLE};
            STEP_CHECK: u = '{accept: 1'b0, emit: 1'b0, cond: COND_EMPTY,
                              jmp_true: STEP_IDLE, jmp_false: STEP_EMIT};
            STEP_EMIT:  u = '{accept: 1'b0, emit: 1'b1, cond: COND_DONE,
                              jmp_true: STEP_IDLE, jmp_false: STEP_EMIT};
            default:    u = '{accept: 1'b0, emit: 1'b0, cond: COND_EMPTY,
                              jmp_true: STEP_IDLE, jmp_false: STEP_IDLE};
        endcase
        return u;
    endfunction

    function automatic logic [7:0] button_mask(input logic [2:0] btn);
        logic [7:0] m;
        case (btn)
            BTN_LEFT:   m = FLAG_LEFT;
            BTN_MIDDLE: m = FLAG_MIDDLE;
            BTN_RIGHT:  m = FLAG_RIGHT;
            default:    m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic t_chunk take_chunk(input t_pend p);
        t_chunk c;
        if (p < -CHUNK_MAX) begin
            c.mv   = BYTE_NEG_MAX;
            c.rest = p + CHUNK_MAX;
        end else if (p > CHUNK_MAX) begin
            c.mv   = BYTE_POS_MAX;
            c.rest = p - CHUNK_MAX;
        end else begin
            c.mv   = p[7:0];
            c.rest = '0;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/mmp_in_if.sv */
// ---------------------------------------------------------------------------
// mmp_in_if
// Pointer event channel: valid/ready handshake with the event fields.
// ---------------------------------------------------------------------------
interface mmp_in_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    mmp_pkg::t_coord       pos_x;
    mmp_pkg::t_coord       pos_y;
    logic [2:0]            button;

    modport source (output valid, output kind, output pos_x, output pos_y,
                    output button, input ready);
    modport sink   (input valid, input kind, input pos_x, input pos_y,
                    input button, output ready);
endinterface

/* hw/rtl/mmp_out_if.sv */
// ---------------------------------------------------------------------------
// mmp_out_if
// Mouse packet channel: valid/ready handshake with the four packet bytes.
// ---------------------------------------------------------------------------
interface mmp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] move_x_byte;
    logic [7:0] move_y_byte;
    logic [7:0] wheel_byte;
    logic       last_packet;

    modport source (output valid, output status_byte, output move_x_byte,
                    output move_y_byte, output wheel_byte, output last_packet,
                    input ready);
    modport sink   (input valid, input status_byte, input move_x_byte,
                    input move_y_byte, input wheel_byte, input last_packet,
                    output ready);
endinterface

/* hw/rtl/mouse_motion_packetizer_top.sv */
// ---------------------------------------------------------------------------
// mouse_motion_packetizer_top
// Turns pointer events into four-byte mouse packets with a wheel byte.
// ---------------------------------------------------------------------------
// Usage:
//   i_evt carries one pointer event per request: absolute motion, button
//   press or button release. o_pkt carries one mouse packet per request;
//   last_packet marks the final packet caused by an event.
//   A small microcode table steps the datapath: wait for an event, check
//   for pending work, then emit packets from a single emit step.
//   After an accepted event the check step runs, then the emit step loads
//   the output register. Throughput: one packet per cycle while o_pkt is
//   ready; an event yields up to 17 packets (a full-range move chopped
//   into steps of 255), and an event with no pending work yields none.
//   i_evt.ready is high only in the wait step.
//   A stalled receiver holds the output register and the emit step; no
//   packet is lost or repeated.
//   Reset clears position, pending movement, buttons, wheel and change
//   flag; no packet is valid after reset.
// ---------------------------------------------------------------------------
module mouse_motion_packetizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mmp_in_if.sink    i_evt,
    mmp_out_if.source o_pkt
);

    mmp_pkg::t_step  r_step,   n_step;
    mmp_pkg::t_coord r_prev_x, n_prev_x;
    mmp_pkg::t_coord r_prev_y, n_prev_y;
    mmp_pkg::t_pend  r_pend_x, n_pend_x;
    mmp_pkg::t_pend  r_pend_y, n_pend_y;
    logic [7:0]      r_status, n_status;
    logic [7:0]      r_wheel,  n_wheel;
    logic            r_change, n_change;

    logic            r_out_valid;
    logic [7:0]      r_out_status;
    logic [7:0]      r_out_x;
    logic [7:0]      r_out_y;
    logic [7:0]      r_out_wheel;
    logic            r_out_last;

    mmp_pkg::t_uop   w_uop;
    mmp_pkg::t_chunk w_cx;
    mmp_pkg::t_chunk w_cy;
    mmp_pkg::t_pend  w_dx;
    mmp_pkg::t_pend  w_dy;
    mmp_pkg::t_pend  w_mx;
    mmp_pkg::t_pend  w_my;
    logic            w_req;
    logic            w_out_free;
    logic            w_emit;
    logic            w_empty;
    logic            w_done;
    logic            w_cond;

    assign w_uop       = mmp_pkg::uop_rom(r_step);
    assign i_evt.ready = w_uop.accept;
    assign w_req       = i_evt.valid && w_uop.accept;
    assign w_out_free  = !r_out_valid || o_pkt.ready;
    assign w_emit      = w_uop.emit && w_out_free;

    assign w_cx    = mmp_pkg::take_chunk(r_pend_x);
    assign w_cy    = mmp_pkg::take_chunk(r_pend_y);
    assign w_empty = (r_pend_x == '0) && (r_pend_y == '0) && !r_change;
    assign w_done  = (w_cx.rest == '0) && (w_cy.rest == '0);

    assign w_dx = mmp_pkg::t_pend'({1'b0, i_evt.pos_x}) - mmp_pkg::t_pend'({1'b0, r_prev_x});
    assign w_dy = mmp_pkg::t_pend'({1'b0, r_prev_y}) - mmp_pkg::t_pend'({1'b0, i_evt.pos_y});
    assign w_mx = r_pend_x + w_dx;
    assign w_my = r_pend_y + w_dy;

    // sequencer: branch on the selected condition
    always_comb begin
        unique case (w_uop.cond)
            mmp_pkg::COND_REQ:   w_cond = w_req;
            mmp_pkg::COND_EMPTY: w_cond = w_empty;
            mmp_pkg::COND_DONE:  w_cond = w_done;
            default:             w_cond = 1'b0;
        endcase
    end

    always_comb begin
        if (w_uop.emit && !w_out_free) begin
            n_step = r_step;
        end else if (w_cond) begin
            n_step = w_uop.jmp_true;
        end else begin
            n_step = w_uop.jmp_false;
        end
    end

    // datapath
    always_comb begin
        n_prev_x = r_prev_x;
        n_prev_y = r_prev_y;
        n_pend_x = r_pend_x;
        n_pend_y = r_pend_y;
        n_status = r_status;
        n_wheel  = r_wheel;
        n_change = r_change;
        if (w_req) begin
            case (i_evt.kind)
                mmp_pkg::KIND_MOTION: begin
                    n_pend_x = w_mx;
                    n_pend_y = w_my;
                    n_status = w_mx[mmp_pkg::PEND_W-1] ? (r_status | mmp_pkg::FLAG_SIGNX)
                                                        : (r_status & ~mmp_pkg::FLAG_SIGNX);
                    n_status = w_my[mmp_pkg::PEND_W-1] ? (n_status | mmp_pkg::FLAG_SIGNY)
                                                        : (n_status & ~mmp_pkg::FLAG_SIGNY);
                    n_prev_x = i_evt.pos_x;
                    n_prev_y = i_evt.pos_y;
                end
                mmp_pkg::KIND_PRESS: begin
                    n_change = 1'b1;
                    n_status = r_status | mmp_pkg::button_mask(i_evt.button);
                    if (i_evt.button == mmp_pkg::BTN_UP) begin
                        n_wheel = mmp_pkg::WHEEL_UP;
                    end else if (i_evt.button == mmp_pkg::BTN_DOWN) begin
                        n_wheel = mmp_pkg::WHEEL_DOWN;
                    end
                end
                mmp_pkg::KIND_RELEASE: begin
                    n_change = 1'b1;
                    n_status = r_status & ~mmp_pkg::button_mask(i_evt.button);
                    if (i_evt.button == mmp_pkg::BTN_UP ||
                        i_evt.button == mmp_pkg::BTN_DOWN) begin
                        n_wheel = mmp_pkg::WHEEL_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end else if (w_emit) begin
            n_pend_x = w_cx.rest;
            n_pend_y = w_cy.rest;
            n_change = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= mmp_pkg::STEP_IDLE;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_pend_x <= '0;
            r_pend_y <= '0;
            r_status <= '0;
            r_wheel  <= '0;
            r_change <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_prev_x <= n_prev_x;
            r_prev_y <= n_prev_y;
            r_pend_x <= n_pend_x;
            r_pend_y <= n_pend_y;
            r_status <= n_status;
            r_wheel  <= n_wheel;
            r_change <= n_change;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pkt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= r_status;
            r_out_x      <= w_cx.mv;
            r_out_y      <= w_cy.mv;
            r_out_wheel  <= r_wheel;
            r_out_last   <= w_done;
        end
    end

    assign o_pkt.valid       = r_out_valid;
    assign o_pkt.status_byte = r_out_status;
    assign o_pkt.move_x_byte = r_out_x;
    assign o_pkt.move_y_byte = r_out_y;
    assign o_pkt.wheel_byte  = r_out_wheel;
    assign o_pkt.last_packet = r_out_last;

`include "mouse_motion_packetizer_top_assert.svh"

    `MMP_ASSERT_NOW(a_req_when_drained, w_req,
        (r_pend_x == '0) && (r_pend_y == '0) && !r_change,
        "event request while packets are still pending")
    `MMP_ASSERT_NOW(a_emit_has_work, r_step == mmp_pkg::STEP_EMIT,
        !w_empty, "emit step with nothing pending")
    `MMP_ASSERT_NEXT(a_last_ends_event, w_emit && w_done,
        r_step == mmp_pkg::STEP_IDLE, "sequencer did not return after last packet")
    `MMP_ASSERT_NEXT(a_stall_holds_step, w_uop.emit && !w_out_free,
        r_step == mmp_pkg::STEP_EMIT, "emit step left while output stalled")

endmodule

/* tb/mouse_motion_packetizer_top_tb.sv */
// ---------------------------------------------------------------------------
// mouse_motion_packetizer_top_tb
// Sends pointer events (motion, press, release, unused kind) through the
// event channel with random gaps while the packet channel stalls at random.
// A model in the bench predicts every packet; each packet taken
// from the block is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module mouse_motion_packetizer_top_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         MAX_STEP    = 255;
    localparam int         COORD_TOP   = (1 << mmp_pkg::COORD_BITS) - 1;
    localparam int         RANDOM_EVTS = 385;
    localparam int         DRAIN_CYC   = 20;
    localparam int         CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]      kind;
        mmp_pkg::t_coord x;
        mmp_pkg::t_coord y;
        logic [2:0]      btn;
    } t_pointer_ev;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] mx;
        logic [7:0] my;
        logic [7:0] wheel;
        logic       last;
    } t_packet;

    logic i_clk;
    logic i_rst_n;

    mmp_in_if  evt_if ();
    mmp_out_if pkt_if ();

    mouse_motion_packetizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_pkt   (pkt_if)
    );

    t_pointer_ev events_to_send[$];
    t_packet     packets_due[$];

    mmp_pkg::t_coord mouse_x;
    mmp_pkg::t_coord mouse_y;
    int         owed_x;
    int         owed_y;
    logic [7:0] held_status;
    logic [7:0] wheel_now;
    logic       change_owed;

    int      errors;
    int      cycles;
    int      n_events;
    int      n_packets;
    int      n_full_steps;
    int      n_still_packets;
    int      evt_gap;
    int      pkt_stall;
    logic    evt_fire;
    t_packet got_pkt;
    t_packet want_pkt;

    int gen_x;
    int gen_y;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int cut_move(inout int rest);
        int c;
        if (rest < -MAX_STEP)
            c = -MAX_STEP;
        else if (rest > MAX_STEP)
            c = MAX_STEP;
        else
            c = rest;
        rest -= c;
        return c;
    endfunction

    function automatic logic [7:0] flag_of_button(logic [2:0] btn);
        logic [7:0] f;
        case (btn)
            mmp_pkg::BTN_LEFT:   f = mmp_pkg::FLAG_LEFT;
            mmp_pkg::BTN_MIDDLE: f = mmp_pkg::FLAG_MIDDLE;
            mmp_pkg::BTN_RIGHT:  f = mmp_pkg::FLAG_RIGHT;
            default:             f = 8'h00;
        endcase
        return f;
    endfunction

    function automatic void packets_for_event(t_pointer_ev ev);
        int      cx;
        int      cy;
        t_packet p;
        if (ev.kind == mmp_pkg::KIND_MOTION) begin
            owed_x += int'(ev.x) - int'(mouse_x);
            owed_y += int'(mouse_y) - int'(ev.y);
            if (owed_x < 0)
                held_status |= mmp_pkg::FLAG_SIGNX;
            else
                held_status &= ~mmp_pkg::FLAG_SIGNX;
            if (owed_y < 0)
                held_status |= mmp_pkg::FLAG_SIGNY;
            else
                held_status &= ~mmp_pkg::FLAG_SIGNY;
            mouse_x = ev.x;
            mouse_y = ev.y;
        end else if (ev.kind == mmp_pkg::KIND_PRESS) begin
            change_owed = 1'b1;
            held_status |= flag_of_button(ev.btn);
            if (ev.btn == mmp_pkg::BTN_UP)
                wheel_now = mmp_pkg::WHEEL_UP;
            else if (ev.btn == mmp_pkg::BTN_DOWN)
                wheel_now = mmp_pkg::WHEEL_DOWN;
        end else if (ev.kind == mmp_pkg::KIND_RELEASE) begin
            change_owed = 1'b1;
            held_status &= ~flag_of_button(ev.btn);
            if (ev.btn == mmp_pkg::BTN_UP || ev.btn == mmp_pkg::BTN_DOWN)
                wheel_now = mmp_pkg::WHEEL_IDLE;
        end else begin
            return;
        end
        while (owed_x != 0 || owed_y != 0 || change_owed) begin
            change_owed = 1'b0;
            cx = cut_move(owed_x);
            cy = cut_move(owed_y);
            p.status = held_status;
            p.mx     = 8'(cx);
            p.my     = 8'(cy);
            p.wheel  = wheel_now;
            p.last   = (owed_x == 0 && owed_y == 0);
            packets_due.push_back(p);
            if (cx == MAX_STEP || cx == -MAX_STEP || cy == MAX_STEP || cy == -MAX_STEP)
                n_full_steps++;
            if (cx == 0 && cy == 0)
                n_still_packets++;
        end
    endfunction

    function automatic void queue_event(logic [1:0] kind, int x, int y, logic [2:0] btn);
        t_pointer_ev ev;
        ev.kind = kind;
        ev.x    = mmp_pkg::t_coord'(x);
        ev.y    = mmp_pkg::t_coord'(y);
        ev.btn  = btn;
        events_to_send.push_back(ev);
    endfunction

    function automatic void queue_motion(int x, int y);
        gen_x = x;
        gen_y = y;
        queue_event(mmp_pkg::KIND_MOTION, x, y, 3'($urandom_range(7)));
    endfunction

    function automatic void queue_button(logic [1:0] kind, logic [2:0] btn);
        queue_event(kind, $urandom_range(COORD_TOP), $urandom_range(COORD_TOP), btn);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_TOP)
            return COORD_TOP;
        return v;
    endfunction

    function automatic int pause_pct();
        int left;
        left = events_to_send.size();
        if (left > 280)
            return 35;
        if (left > 180)
            return 0;
        if (left > 60)
            return 15;
        return 0;
    endfunction

    task automatic check_byte(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else if (!evt_if.valid || evt_fire) begin
            if (evt_gap == 0 && $urandom_range(99) < pause_pct())
                evt_gap = $urandom_range(9, 1);
            if (evt_gap > 0 || events_to_send.size() == 0) begin
                if (evt_gap > 0)
                    evt_gap--;
                evt_if.valid <= 1'b0;
            end else begin
                evt_if.valid  <= 1'b1;
                evt_if.kind   <= events_to_send[0].kind;
                evt_if.pos_x  <= events_to_send[0].x;
                evt_if.pos_y  <= events_to_send[0].y;
                evt_if.button <= events_to_send[0].btn;
                void'(events_to_send.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pkt_if.ready <= 1'b0;
        end else begin
            if (pkt_stall == 0 && $urandom_range(99) < pause_pct())
                pkt_stall = $urandom_range(9, 1);
            if (pkt_stall > 0) begin
                pkt_stall--;
                pkt_if.ready <= 1'b0;
            end else begin
                pkt_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        evt_fire <= i_rst_n && evt_if.valid && evt_if.ready;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            packets_for_event('{evt_if.kind, evt_if.pos_x, evt_if.pos_y, evt_if.button});
            n_events++;
        end
        if (i_rst_n && pkt_if.valid && pkt_if.ready) begin
            got_pkt = '{pkt_if.status_byte, pkt_if.move_x_byte, pkt_if.move_y_byte,
                        pkt_if.wheel_byte, pkt_if.last_packet};
            n_packets++;
            if (packets_due.size() == 0) begin
                $display("%0t: unexpected packet, expected none, got %h", $time, got_pkt);
                errors++;
            end else begin
                want_pkt = packets_due.pop_front();
                check_byte("status_byte", want_pkt.status, got_pkt.status);
                check_byte("move_x_byte", want_pkt.mx, got_pkt.mx);
                check_byte("move_y_byte", want_pkt.my, got_pkt.my);
                check_byte("wheel_byte", want_pkt.wheel, got_pkt.wheel);
                check_byte("last_packet", 8'(want_pkt.last), 8'(got_pkt.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int counted;
        int r;
        int b;
        int k;
        i_rst_n       = 1'b0;
        evt_if.valid  = 1'b0;
        evt_if.kind   = mmp_pkg::KIND_MOTION;
        evt_if.pos_x  = '0;
        evt_if.pos_y  = '0;
        evt_if.button = '0;
        pkt_if.ready  = 1'b0;
        evt_fire      = 1'b0;
        mouse_x       = '0;
        mouse_y       = '0;
        owed_x        = 0;
        owed_y        = 0;
        held_status   = '0;
        wheel_now     = mmp_pkg::WHEEL_IDLE;
        change_owed   = 1'b0;
        errors        = 0;
        cycles        = 0;
        n_events      = 0;
        n_packets     = 0;
        n_full_steps  = 0;
        n_still_packets = 0;
        evt_gap       = 0;
        pkt_stall     = 0;
        gen_x         = 0;
        gen_y         = 0;

        // full-range moves, then a move to the same spot
        queue_motion(COORD_TOP, 0);
        queue_motion(0, COORD_TOP);
        queue_motion(0, COORD_TOP);
        queue_button(mmp_pkg::KIND_PRESS, mmp_pkg::BTN_LEFT);
        queue_button(mmp_pkg::KIND_PRESS, mmp_pkg::BTN_MIDDLE);
        queue_button(mmp_pkg::KIND_PRESS, mmp_pkg::BTN_RIGHT);
        queue_button(mmp_pkg::KIND_PRESS, mmp_pkg::BTN_UP);
        queue_button(mmp_pkg::KIND_PRESS, mmp_pkg::BTN_DOWN);
        queue_button(mmp_pkg::KIND_RELEASE, mmp_pkg::BTN_UP);
        queue_button(mmp_pkg::KIND_PRESS, mmp_pkg::BTN_DOWN);
        queue_button(mmp_pkg::KIND_RELEASE, mmp_pkg::BTN_DOWN);
        // steps right at and just past one chunk
        queue_motion(MAX_STEP, COORD_TOP - MAX_STEP);
        queue_motion(2 * MAX_STEP + 1, COORD_TOP - 2 * MAX_STEP - 1);
        queue_motion(MAX_STEP + 1, COORD_TOP - MAX_STEP - 1);
        queue_motion(0, COORD_TOP);
        // buttons with no meaning still send a packet
        queue_button(mmp_pkg::KIND_PRESS, 3'd0);
        queue_button(mmp_pkg::KIND_PRESS, 3'd6);
        queue_button(mmp_pkg::KIND_PRESS, 3'd7);
        queue_button(mmp_pkg::KIND_RELEASE, 3'd0);
        queue_button(mmp_pkg::KIND_RELEASE, 3'd6);
        queue_button(mmp_pkg::KIND_RELEASE, 3'd7);
        queue_button(mmp_pkg::KIND_RELEASE, mmp_pkg::BTN_LEFT);
        queue_button(mmp_pkg::KIND_RELEASE, mmp_pkg::BTN_MIDDLE);
        queue_button(mmp_pkg::KIND_RELEASE, mmp_pkg::BTN_RIGHT);
        queue_event(KIND_UNUSED, COORD_TOP, COORD_TOP, 3'd7);

        counted = 0;
        while (counted < RANDOM_EVTS) begin
            r = $urandom_range(99);
            if (r < 6) begin
                queue_event(KIND_UNUSED, $urandom_range(COORD_TOP),
                            $urandom_range(COORD_TOP), 3'($urandom_range(7)));
            end else if (r < 50) begin
                queue_motion(clamp_coord(gen_x + int'($urandom_range(1200)) - 600),
                             clamp_coord(gen_y + int'($urandom_range(1200)) - 600));
                counted++;
            end else if (r < 60) begin
                queue_motion($urandom_range(COORD_TOP), $urandom_range(COORD_TOP));
                counted++;
            end else if (r < 64) begin
                queue_motion(gen_x, gen_y);
                counted++;
            end else if (r < 80) begin
                // press, drag a little, release
                b = $urandom_range(5, 1);
                queue_button(mmp_pkg::KIND_PRESS, 3'(b));
                k = $urandom_range(3, 1);
                repeat (k)
                    queue_motion(clamp_coord(gen_x + int'($urandom_range(300)) - 150),
                                 clamp_coord(gen_y + int'($urandom_range(300)) - 150));
                queue_button(mmp_pkg::KIND_RELEASE, 3'(b));
                counted += k + 2;
            end else if (r < 93) begin
                queue_button($urandom_range(1) ? mmp_pkg::KIND_PRESS : mmp_pkg::KIND_RELEASE,
                             3'($urandom_range(5, 1)));
                counted++;
            end else begin
                queue_button($urandom_range(1) ? mmp_pkg::KIND_PRESS : mmp_pkg::KIND_RELEASE,
                             3'($urandom_range(7)));
                counted++;
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (events_to_send.size() != 0 || evt_if.valid)
            @(posedge i_clk);
        while (packets_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (packets_due.size() != 0) begin
            $display("%0t: packets left over, expected 0, got %0d", $time, packets_due.size());
            errors++;
        end

        $display("Covered %0d pointer events and %0d packets: %0d with a full 255 step,",
                 n_events, n_packets, n_full_steps);
        $display("%0d without movement, under random event gaps and packet stalls.",
                 n_still_packets);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
